/* rtl/core/msrdq_pkg.sv */
package msrdq_pkg;

    localparam int QueueDepth   = 8;
    localparam int PayloadBytes = 32;
    localparam int PollSlots    = 8;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAITLEN = 2'd1,
        PH_RECEIVE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_POLL   = 2'd1,
        KIND_SEND   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SEARCH = 2'd1,
        BK_COPY   = 2'd2,
        BK_EMIT   = 2'd3
    } t_bstate;

    localparam logic [1:0] REG_FIRST_ADDR = 2'd0;

    // one classified pass handed from front to back
    typedef struct packed {
        logic       done;
        logic [7:0] addr;
        logic [5:0] len;
        logic       busy;
    } t_pass;

endpackage

/* rtl/core/msrdq_front.sv */
module msrdq_front #(
    parameter int PAYLOAD_BYTES = msrdq_pkg::PayloadBytes
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_has_byte,
    input  logic [7:0]           i_byte_value,
    input  logic [7:0]           i_first_addr,
    output logic                 o_q_valid,
    input  logic                 i_q_stall,
    output msrdq_pkg::t_pass     o_q_pass,
    input  logic [4:0]           i_asm_raddr,
    output logic [7:0]           o_asm_rdata
);
    import msrdq_pkg::*;

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    t_phase     r_phase;
    logic [7:0] r_left, r_addr, r_exp, r_cnt;
    logic [7:0] r_asm [PAYLOAD_BYTES];
    logic [7:0] r_rdata;
    logic       r_qv;
    t_pass      r_qp;

    logic       acc;
    t_phase     n_phase;
    logic [7:0] n_left, n_addr, n_exp, n_cnt, cnt1;
    logic       done;
    logic [7:0] lensat;

    assign o_stall = r_qv;
    assign acc     = i_valid && !r_qv;
    assign cnt1    = r_cnt + 8'd1;
    assign lensat  = (r_exp > 8'(PAYLOAD_BYTES)) ? 8'(PAYLOAD_BYTES) : r_exp;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_addr  = r_addr;
        n_exp   = r_exp;
        n_cnt   = r_cnt;
        done    = 1'b0;
        if (i_has_byte) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte_value != 8'd0) begin
                        n_left  = i_byte_value;
                        n_addr  = i_first_addr;
                        n_phase = PH_WAITLEN;
                    end
                end
                PH_WAITLEN: begin
                    if (i_byte_value == 8'd0) begin
                        n_addr  = r_addr + 8'd1;
                        n_left  = r_left - 8'd1;
                        n_phase = (r_left == 8'd1) ? PH_IDLE : PH_WAITLEN;
                    end else begin
                        n_exp   = i_byte_value;
                        n_cnt   = 8'd0;
                        n_phase = PH_RECEIVE;
                    end
                end
                default: begin
                    n_cnt = cnt1;
                    if (cnt1 == r_exp) begin
                        done    = 1'b1;
                        n_addr  = r_addr + 8'd1;
                        n_left  = r_left - 8'd1;
                        n_phase = (r_left == 8'd1) ? PH_IDLE : PH_WAITLEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_addr  <= '0;
            r_exp   <= '0;
            r_cnt   <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_addr  <= n_addr;
                r_exp   <= n_exp;
                r_cnt   <= n_cnt;
                r_qv    <= 1'b1;
            end else if (r_qv && !i_q_stall) begin
                r_qv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_qp.done <= done;
            r_qp.addr <= r_addr;
            r_qp.len  <= 6'(lensat);
            r_qp.busy <= (n_phase != PH_IDLE);
        end
        if (acc && i_has_byte && r_phase == PH_RECEIVE && r_cnt < 8'(PAYLOAD_BYTES))
            r_asm[r_cnt[AW-1:0]] <= i_byte_value;
        r_rdata <= r_asm[i_asm_raddr[AW-1:0]];
    end

    assign o_q_valid   = r_qv;
    assign o_q_pass    = r_qp;
    assign o_asm_rdata = r_rdata;
endmodule

/* rtl/core/msrdq_back.sv */
module msrdq_back #(
    parameter int QUEUE_DEPTH   = msrdq_pkg::QueueDepth,
    parameter int PAYLOAD_BYTES = msrdq_pkg::PayloadBytes,
    parameter int POLL_SLOTS    = msrdq_pkg::PollSlots
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_stall,
    input  msrdq_pkg::t_pass     i_q_pass,
    output logic [4:0]           o_asm_raddr,
    input  logic [7:0]           i_asm_rdata,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_slave_address,
    output logic [7:0]           o_data_byte,
    output logic                 o_last,
    output logic                 o_busy_res,
    output logic                 o_dropped
);
    import msrdq_pkg::*;

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BW  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int PW  = (POLL_SLOTS > 1) ? $clog2(POLL_SLOTS) : 1;
    localparam int PCW = $clog2(POLL_SLOTS + 1);
    localparam int LW  = $clog2(PAYLOAD_BYTES + 1);
    localparam int MD  = QUEUE_DEPTH * PAYLOAD_BYTES;
    localparam int MW  = $clog2(MD);

    // ring storage
    logic [QUEUE_DEPTH-1:0] r_sv;
    logic [7:0]    r_sa [QUEUE_DEPTH];
    logic [LW-1:0] r_sl [QUEUE_DEPTH];
    logic [7:0]    r_mem [MD];
    logic [7:0]    r_mrd;
    logic [7:0]    r_pl [POLL_SLOTS];
    logic [QW-1:0]  r_drain;
    logic [PCW-1:0] r_pcnt;
    logic [PW-1:0]  r_pcur;

    t_bstate        r_st, n_st;
    t_pass          r_pass;
    logic [QW-1:0]  r_idx;
    logic [QW:0]    r_n;
    logic [LW:0]    r_i;      // copy / send byte counter
    logic           r_drop;
    logic [1:0]     r_sub;    // 0 status, 1 poll, 2 send
    logic           r_ov;
    logic           r_rdok;   // memory read data for r_i valid
    logic [1:0]     r_okind;
    logic [7:0]     r_oaddr, r_odata;
    logic           r_olast, r_obusy, r_odrop;

    logic           out_free;
    logic           has_poll, has_send, dup;
    logic [PW-1:0]  cur;
    logic [QW-1:0]  drain_next;

    assign out_free   = !r_ov || !i_stall;
    assign o_q_stall  = (r_st != BK_IDLE);
    assign has_poll   = (r_pcnt != '0);
    assign has_send   = r_sv[r_drain];
    assign cur        = (PCW'(r_pcur) >= r_pcnt) ? '0 : r_pcur;
    assign drain_next = (r_drain == QW'(QUEUE_DEPTH - 1)) ? '0 : r_drain + QW'(1);
    assign o_asm_raddr = 5'(r_i[BW-1:0]);

    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < POLL_SLOTS; k++)
            if (PCW'(k) < r_pcnt && r_pl[k] == r_pass.addr) dup = 1'b1;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE:   if (i_q_valid) n_st = i_q_valid && !i_q_pass.done ? BK_EMIT : BK_SEARCH;
            BK_SEARCH: begin
                if (!r_sv[r_idx]) n_st = BK_COPY;
                else if (r_n == (QW+1)'(QUEUE_DEPTH - 1)) n_st = BK_EMIT;
            end
            BK_COPY:   if (r_i == (LW+1)'(r_pass.len)) n_st = BK_EMIT;
            default:   ;
        endcase
    end

    // the emit state walks status, poll, then send beats
    logic emit_beat;
    logic [1:0] e_kind;
    logic [7:0] e_addr, e_data;
    logic       e_last;
    logic [LW-1:0] slen;
    assign slen = r_sl[r_drain];

    always_comb begin
        emit_beat = 1'b0;
        e_kind = KIND_STATUS;
        e_addr = '0;
        e_data = '0;
        e_last = 1'b0;
        if (r_st == BK_EMIT && out_free) begin
            unique case (r_sub)
                2'd0: begin
                    emit_beat = 1'b1;
                    e_last = !has_poll && !(has_send && slen != '0);
                end
                2'd1: begin
                    emit_beat = 1'b1;
                    e_kind = KIND_POLL;
                    e_addr = r_pl[cur];
                    e_last = !(has_send && slen != '0);
                end
                default: begin
                    emit_beat = r_rdok;
                    e_kind = KIND_SEND;
                    e_addr = r_sa[r_drain];
                    e_data = r_mrd;
                    e_last = (r_i + (LW+1)'(1) == (LW+1)'(slen));
                end
            endcase
        end
    end

    logic [MW-1:0] rd_a;
    assign rd_a = MW'({r_drain, r_i[BW-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= BK_IDLE;
            r_sv    <= '0;
            r_drain <= '0;
            r_pcnt  <= '0;
            r_pcur  <= '0;
            r_ov    <= 1'b0;
            r_sub   <= '0;
            r_rdok  <= 1'b0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_idx   <= '0;
            r_n     <= '0;
        end else begin
            if (r_ov && !i_stall && !emit_beat) r_ov <= 1'b0;
            r_rdok <= (r_st == BK_EMIT) && (r_sub == 2'd2) && !r_rdok && !emit_beat;
            unique case (r_st)
                BK_IDLE: begin
                    if (i_q_valid) begin
                        r_pass <= i_q_pass;
                        r_drop <= 1'b0;
                        r_idx  <= r_drain;
                        r_n    <= '0;
                        r_i    <= '0;
                        r_sub  <= '0;
                        r_st   <= n_st;
                    end
                end
                BK_SEARCH: begin
                    if (!r_sv[r_idx]) begin
                        r_i <= '0;
                    end else begin
                        if (n_st == BK_EMIT) r_drop <= 1'b1;
                        r_idx <= (r_idx == QW'(QUEUE_DEPTH - 1)) ? '0 : r_idx + QW'(1);
                        r_n   <= r_n + (QW+1)'(1);
                    end
                    r_st <= n_st;
                end
                BK_COPY: begin
                    // asm read is registered: write byte i-1 while reading byte i
                    if (r_i == (LW+1)'(r_pass.len)) begin
                        r_sv[r_idx] <= 1'b1;
                        r_sa[r_idx] <= r_pass.addr;
                        r_sl[r_idx] <= LW'(r_pass.len);
                        if (!dup && r_pcnt < PCW'(POLL_SLOTS)) begin
                            r_pl[r_pcnt[PW-1:0]] <= r_pass.addr;
                            r_pcnt <= r_pcnt + PCW'(1);
                        end
                        r_i <= '0;
                    end else begin
                        r_i <= r_i + (LW+1)'(1);
                    end
                    r_st <= n_st;
                end
                default: begin
                    if (emit_beat) begin
                        r_ov    <= 1'b1;
                        r_okind <= e_kind;
                        r_oaddr <= e_addr;
                        r_odata <= e_data;
                        r_olast <= e_last;
                        r_obusy <= r_pass.busy;
                        r_odrop <= r_drop;
                        unique case (r_sub)
                            2'd0: if (!e_last) r_sub <= has_poll ? 2'd1 : 2'd2;
                            2'd1: begin
                                if (!e_last) r_sub <= 2'd2;
                                r_pcur <= (PCW'(cur) + PCW'(1) >= r_pcnt) ? '0 : cur + PW'(1);
                            end
                            default: begin
                                r_i <= r_i + (LW+1)'(1);
                            end
                        endcase
                    end
                    if (e_last && emit_beat || (r_sub == 2'd2 && !(has_send && slen != '0))) begin
                        if (has_send) begin
                            r_sv[r_drain] <= 1'b0;
                            r_drain <= drain_next;
                        end
                        r_st <= BK_IDLE;
                        r_sub <= '0;
                    end
                end
            endcase
        end
    end

    // copy writes come in the cycle after the assembly read
    logic          r_cw;
    logic [MW-1:0] r_cwa;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cw <= 1'b0;
        else r_cw <= (r_st == BK_COPY) && (r_i != (LW+1)'(r_pass.len));
        r_cwa <= MW'({r_idx, r_i[BW-1:0]});
        if (r_cw) r_mem[r_cwa] <= i_asm_rdata;
        r_mrd <= r_mem[rd_a];
    end

    assign o_valid         = r_ov;
    assign o_kind          = r_okind;
    assign o_slave_address = r_oaddr;
    assign o_data_byte     = r_odata;
    assign o_last          = r_olast;
    assign o_busy_res      = r_obusy;
    assign o_dropped       = r_odrop;
endmodule

/* rtl/core/multi_slave_request_deframer_queue_core.sv */
// timing: the status beat follows an accepted input beat through the front pass
//   register, the back end's state and the output register; a pass that finishes a payload
//   first searches the ring and, if a slot is free, copies the payload. Emit beats wait while
//   the output stalls; the front end takes no new input beat until the back end has its pass.
// reset: synchronous active-low; parser idle, ring empty, poll list empty,
//   first_slave_address back to 1
module multi_slave_request_deframer_queue_core #(
    parameter int QUEUE_DEPTH   = msrdq_pkg::QueueDepth,
    parameter int PAYLOAD_BYTES = msrdq_pkg::PayloadBytes,
    parameter int POLL_SLOTS    = msrdq_pkg::PollSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_has_byte,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_slave_address,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic        o_busy_res,
    output logic        o_dropped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import msrdq_pkg::*;

    logic [7:0] r_first;
    logic       qv, qs;
    t_pass      qp;
    logic [4:0] ara;
    logic [7:0] ard;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first <= 8'd1;
        else if (psel && penable && pwrite && paddr == {REG_FIRST_ADDR[1:0]})
            r_first <= pwdata[7:0];
    end
    assign prdata = (paddr == REG_FIRST_ADDR) ? {24'd0, r_first} : 32'd0;

    msrdq_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_has_byte(i_has_byte), .i_byte_value(i_byte_value),
        .i_first_addr(r_first), .o_q_valid(qv), .i_q_stall(qs), .o_q_pass(qp),
        .i_asm_raddr(ara), .o_asm_rdata(ard)
    );

    msrdq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH), .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .POLL_SLOTS(POLL_SLOTS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(qv), .o_q_stall(qs),
        .i_q_pass(qp), .o_asm_raddr(ara), .i_asm_rdata(ard),
        .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind),
        .o_slave_address(o_slave_address), .o_data_byte(o_data_byte),
        .o_last(o_last), .o_busy_res(o_busy_res), .o_dropped(o_dropped)
    );
endmodule

/* rtl/core/msrdq_checker.sv */
module msrdq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_slave_address,
    input logic [7:0] o_data_byte
);
    import msrdq_pkg::*;

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind != 2'd3)) else $error("bad kind");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS |-> o_slave_address == 8'd0 && o_data_byte == 8'd0)
        else $error("status not clean");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind)) else $error("stall drop");
endmodule

bind multi_slave_request_deframer_queue_core msrdq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_kind(o_kind), .o_slave_address(o_slave_address), .o_data_byte(o_data_byte)
);
